### hdl/cbmwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper package
// Types and constants shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package cbmwg_pkg;

    localparam int unsigned WRAM_BYTES  = 8192;
    localparam int unsigned WRAM_AW     = $clog2(WRAM_BYTES);
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned ROM_AW      = 19;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Result kind as seen on the output channel.
    typedef enum logic [2:0] {
        KIND_REG       = 3'd0,
        KIND_RAM_WRITE = 3'd1,
        KIND_RAM_READ  = 3'd2,
        KIND_OPEN_BUS  = 3'd3,
        KIND_PRG       = 3'd4,
        KIND_CHR       = 3'd5,
        KIND_IGNORED   = 3'd6
    } t_kind;

    // Work RAM operation left for the back end.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [WRAM_AW-1:0]  ram_addr;
        logic [DATA_W-1:0]   data;
        t_kind               kind;
        logic [ROM_AW-1:0]   rom_address;
        logic                mirror_vertical;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic queue_full;
        logic ram_clearing;
    } t_hold;

endpackage

### hdl/cartridge_bank_mapper_wram_guard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper with guarded work RAM
// Top level: front end, item queue and back end with the 8 KB work RAM.
// ----------------------------------------------------------------------------
// Usage. Each bus access (CPU write, CPU read or PPU pattern fetch) is an item
// offered on the input channel with i_in_valid; it is taken at a clock edge
// where o_in_stall is low. Every item yields exactly one result item on the
// output channel, held in o_out_* while o_out_valid is high and i_out_stall is
// high, and taken at an edge where i_out_stall is low.
// Items go from the queue through the back end's first stage to the output
// register. One item per cycle is sustained: the front end decodes and updates
// the bank registers in the cycle of acceptance, the back end gives the single
// work RAM read port one item per cycle, and the RAM read data is registered
// once before the output register. When the receiver stalls, a four-entry
// queue keeps taking items until it is full; o_in_stall then rises and falls
// again as soon as results drain. Reset (synchronous, active low) returns all
// registers to their reset values and starts a clearing pass that writes zero
// to every work RAM byte, one byte a cycle; o_in_stall is high throughout.
// Configuration writes on i_cfg_* are also taken during the clearing pass.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_wram_guard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_in_func,
    input  logic [15:0] i_in_address,
    input  logic [7:0]  i_in_write_data,
    input  logic [7:0]  i_in_open_bus_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_out_kind,
    output logic [7:0]  o_out_read_data,
    output logic [18:0] o_out_rom_address,
    output logic        o_out_mirror_vertical,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    cbmwg_pkg::t_hold         w_hold;
    cbmwg_pkg::t_queue_status w_q_status;
    cbmwg_pkg::t_entry        w_push_entry;
    cbmwg_pkg::t_entry        w_pop_entry;
    logic                     w_push;
    logic                     w_pop;
    logic                     w_clearing;

    // The front end holds off new items while the queue is full or the RAM
    // is still being cleared.
    assign w_hold.queue_full   = w_q_status.full;
    assign w_hold.ram_clearing = w_clearing;

    cbmwg_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_func          (i_in_func),
        .i_in_address       (i_in_address),
        .i_in_write_data    (i_in_write_data),
        .i_in_open_bus_data (i_in_open_bus_data),
        .o_in_stall         (o_in_stall),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_hold             (w_hold),
        .o_push             (w_push),
        .o_entry            (w_push_entry)
    );

    cbmwg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_entry  (w_pop_entry),
        .o_status (w_q_status)
    );

    // The back end sees items in order, so RAM reads always follow the writes
    // accepted before them.
    cbmwg_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_q_valid             (~w_q_status.empty),
        .i_q_entry             (w_pop_entry),
        .o_pop                 (w_pop),
        .o_clearing            (w_clearing),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_out_kind            (o_out_kind),
        .o_out_read_data       (o_out_read_data),
        .o_out_rom_address     (o_out_rom_address),
        .o_out_mirror_vertical (o_out_mirror_vertical)
    );

    // Reset always starts a clearing pass.
    a_reset_starts_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> w_clearing)
        else $error("work RAM clearing pass not started by reset");

    // No result can be presented while the RAM is still being cleared.
    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_out_valid)
        else $error("result presented during work RAM clearing pass");

    // Nothing may have been queued by the time the clearing pass ends.
    a_queue_empty_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_clearing) |-> w_q_status.empty)
        else $error("item queued during work RAM clearing pass");

endmodule

### hdl/cbmwg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered and holds while
// no read is requested.
// ----------------------------------------------------------------------------
module cbmwg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cbmwg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper front end
// Accepts bus accesses, holds the bank, key and control registers, and turns
// each access into a queue entry with its kind and ROM address.
// ----------------------------------------------------------------------------
module cbmwg_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [1:0]                 i_in_func,
    input  logic [15:0]                i_in_address,
    input  logic [7:0]                 i_in_write_data,
    input  logic [7:0]                 i_in_open_bus_data,
    output logic                       o_in_stall,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [7:0]                 i_cfg_data,
    input  cbmwg_pkg::t_hold           i_hold,
    output logic                       o_push,
    output cbmwg_pkg::t_entry          o_entry
);

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_FETCH = 2'd2;

    localparam logic [1:0] CFG_BANK_ORDER = 2'd0;
    localparam logic [1:0] CFG_PRG_MASK   = 2'd1;
    localparam logic [1:0] CFG_CHR_MASK   = 2'd2;

    localparam logic [3:0] SLOT_CHR_FIRST = 4'h0;
    localparam logic [3:0] SLOT_CHR_LAST  = 4'h5;
    localparam logic [3:0] SLOT_CONTROL   = 4'h6;
    localparam logic [3:0] SLOT_KEY_FIRST = 4'h7;
    localparam logic [3:0] SLOT_KEY_LAST  = 4'h9;
    localparam logic [3:0] SLOT_PRG_FIRST = 4'hA;
    localparam logic [3:0] SLOT_PRG_LAST  = 4'hC;

    localparam logic [7:0] KEY_LOW  = 8'hCA;
    localparam logic [7:0] KEY_MID  = 8'h69;
    localparam logic [7:0] KEY_HIGH = 8'h84;

    localparam logic [11:0] REG_WINDOW     = 12'h7EF;
    localparam logic [15:0] WRAM_BASE      = 16'h6000;
    localparam logic [15:0] WRAM_OPEN_BASE = 16'h7400;
    localparam logic [15:0] PPU_LIMIT      = 16'h2000;

    localparam logic [7:0] PRG_MASK_RESET = 8'd15;
    localparam logic [7:0] CHR_MASK_RESET = 8'd127;

    logic [7:0] r_chr_bank [6];
    logic [7:0] r_prg_bank [3];
    logic [7:0] r_guard_key [3];
    logic [1:0] r_control;
    logic       r_bank_order_reversed;
    logic [5:0] r_prg_bank_mask;
    logic [7:0] r_chr_bank_mask;

    logic              w_accept;
    logic              w_reg_we;
    logic [3:0]        w_slot;
    logic [1:0]        w_key_idx;
    logic [1:0]        w_prg_idx;
    logic              w_guard_open;
    logic [7:0]        w_prg_reg;
    logic [5:0]        w_prg_num;
    logic              w_chr_high;
    logic [2:0]        w_chr_idx;
    logic [7:0]        w_chr_reg;
    logic [7:0]        w_chr_num;
    cbmwg_pkg::t_entry w_entry;

    function automatic logic [5:0] prg_number(input logic rev, input logic [7:0] v);
        if (rev) begin
            return {v[0], v[1], v[2], v[3], v[4], v[5]};
        end
        return v[7:2];
    endfunction

    assign o_in_stall = i_hold.queue_full | i_hold.ram_clearing;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign o_push     = w_accept;

    assign w_slot    = i_in_address[3:0];
    assign w_key_idx = 2'(w_slot - SLOT_KEY_FIRST);
    assign w_prg_idx = 2'(w_slot - SLOT_PRG_FIRST);

    // Each guarded slice of the work RAM opens on its own key.
    assign w_guard_open =
        (i_in_address[15:11] == 5'b01100 && r_guard_key[0] == KEY_LOW) ||
        (i_in_address[15:11] == 5'b01101 && r_guard_key[1] == KEY_MID) ||
        (i_in_address[15:10] == 6'b011100 && r_guard_key[2] == KEY_HIGH);

    // The window at 0xE000 is pinned to the last bank.
    always_comb begin
        case (i_in_address[14:13])
            2'd0:    w_prg_reg = r_prg_bank[0];
            2'd1:    w_prg_reg = r_prg_bank[1];
            2'd2:    w_prg_reg = r_prg_bank[2];
            default: w_prg_reg = '0;
        endcase
        if (i_in_address[14:13] == 2'd3) begin
            w_prg_num = 6'h3F;
        end else begin
            w_prg_num = prg_number(r_bank_order_reversed, w_prg_reg);
        end
    end

    // Lower half uses 2 KB banks, upper half 1 KB banks; control bit 1 swaps halves.
    assign w_chr_high = i_in_address[12] ^ r_control[1];
    assign w_chr_idx  = w_chr_high ? 3'(3'd2 + {1'b0, i_in_address[11:10]})
                                   : {2'b00, i_in_address[11]};
    assign w_chr_reg  = r_chr_bank[w_chr_idx];
    assign w_chr_num  = w_chr_high ? w_chr_reg : {w_chr_reg[7:1], i_in_address[10]};

    always_comb begin
        w_entry                 = '0;
        w_entry.op              = cbmwg_pkg::OP_NONE;
        w_entry.ram_addr        = i_in_address[cbmwg_pkg::WRAM_AW-1:0];
        w_entry.kind            = cbmwg_pkg::KIND_IGNORED;
        w_entry.mirror_vertical = r_control[0];
        w_reg_we                = 1'b0;
        case (i_in_func)
            FUNC_WRITE: begin
                if (i_in_address[15:4] == REG_WINDOW) begin
                    if (w_slot <= SLOT_PRG_LAST) begin
                        w_entry.kind = cbmwg_pkg::KIND_REG;
                        w_reg_we     = 1'b1;
                        if (w_slot == SLOT_CONTROL) begin
                            w_entry.mirror_vertical = i_in_write_data[0];
                        end
                    end
                end else if (w_guard_open) begin
                    w_entry.op   = cbmwg_pkg::OP_WRITE;
                    w_entry.kind = cbmwg_pkg::KIND_RAM_WRITE;
                    w_entry.data = i_in_write_data;
                end
            end
            FUNC_READ: begin
                if (i_in_address[15]) begin
                    w_entry.kind        = cbmwg_pkg::KIND_PRG;
                    w_entry.rom_address = {w_prg_num & r_prg_bank_mask,
                                           i_in_address[12:0]};
                end else if (i_in_address >= WRAM_OPEN_BASE || w_guard_open) begin
                    w_entry.op   = cbmwg_pkg::OP_READ;
                    w_entry.kind = cbmwg_pkg::KIND_RAM_READ;
                end else if (i_in_address >= WRAM_BASE) begin
                    w_entry.kind = cbmwg_pkg::KIND_OPEN_BUS;
                    w_entry.data = i_in_open_bus_data;
                end
            end
            FUNC_FETCH: begin
                if (i_in_address < PPU_LIMIT) begin
                    w_entry.kind        = cbmwg_pkg::KIND_CHR;
                    w_entry.rom_address = {1'b0, w_chr_num & r_chr_bank_mask,
                                           i_in_address[9:0]};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_entry = w_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_chr_bank[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_prg_bank[i]  <= '0;
                r_guard_key[i] <= '0;
            end
            r_control             <= '0;
            r_bank_order_reversed <= 1'b0;
            r_prg_bank_mask       <= PRG_MASK_RESET[5:0];
            r_chr_bank_mask       <= CHR_MASK_RESET;
        end else begin
            if (w_accept && w_reg_we) begin
                case (w_slot) inside
                    [SLOT_CHR_FIRST:SLOT_CHR_LAST]: r_chr_bank[w_slot[2:0]] <= i_in_write_data;
                    SLOT_CONTROL:                   r_control <= i_in_write_data[1:0];
                    [SLOT_KEY_FIRST:SLOT_KEY_LAST]: r_guard_key[w_key_idx] <= i_in_write_data;
                    [SLOT_PRG_FIRST:SLOT_PRG_LAST]: r_prg_bank[w_prg_idx] <= i_in_write_data;
                    default: begin
                    end
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BANK_ORDER: r_bank_order_reversed <= i_cfg_data[0];
                    CFG_PRG_MASK:   r_prg_bank_mask <= i_cfg_data[5:0];
                    CFG_CHR_MASK:   r_chr_bank_mask <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

### hdl/cbmwg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper queue
// Short first-in first-out buffer of decoded items between front and back.
// ----------------------------------------------------------------------------
module cbmwg_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  cbmwg_pkg::t_entry        i_entry,
    input  logic                     i_pop,
    output cbmwg_pkg::t_entry        o_entry,
    output cbmwg_pkg::t_queue_status o_status
);

    localparam int unsigned PW = $clog2(cbmwg_pkg::QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(cbmwg_pkg::QUEUE_DEPTH + 1);

    cbmwg_pkg::t_entry r_mem [cbmwg_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_entry        = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(cbmwg_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/cbmwg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank mapper back end
// Owns the work RAM: clears it after reset, carries out queued reads and
// writes, and presents results through an output register.
// ----------------------------------------------------------------------------
module cbmwg_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  cbmwg_pkg::t_entry       i_q_entry,
    output logic                    o_pop,
    output logic                    o_clearing,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [2:0]              o_out_kind,
    output logic [7:0]              o_out_read_data,
    output logic [18:0]             o_out_rom_address,
    output logic                    o_out_mirror_vertical
);

    localparam int unsigned AW = cbmwg_pkg::WRAM_AW;

    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;
    logic              r_s1_valid;
    cbmwg_pkg::t_entry r_s1;
    logic              r_out_valid;
    logic [2:0]        r_out_kind;
    logic [7:0]        r_out_read_data;
    logic [18:0]       r_out_rom_address;
    logic              r_out_mirror;

    logic          w_out_free;
    logic          w_s1_advance;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [7:0]    w_ram_wdata;
    logic          w_ram_re;
    logic [7:0]    w_ram_rdata;
    logic [7:0]    w_s1_read_data;

    assign w_out_free   = ~r_out_valid | ~i_out_stall;
    assign w_s1_advance = ~r_s1_valid | w_out_free;
    assign o_pop        = i_q_valid & w_s1_advance & ~r_clearing;

    assign w_ram_we    = r_clearing | (o_pop && i_q_entry.op == cbmwg_pkg::OP_WRITE);
    assign w_ram_waddr = r_clearing ? r_clr_addr : i_q_entry.ram_addr;
    assign w_ram_wdata = r_clearing ? 8'h00 : i_q_entry.data;
    assign w_ram_re    = o_pop && i_q_entry.op == cbmwg_pkg::OP_READ;

    cbmwg_ram #(
        .WIDTH (8),
        .DEPTH (cbmwg_pkg::WRAM_BYTES)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (i_q_entry.ram_addr),
        .o_rdata (w_ram_rdata)
    );

    // RAM read data belongs to the item in the first stage; a write returns zero.
    always_comb begin
        case (r_s1.op)
            cbmwg_pkg::OP_READ:  w_s1_read_data = w_ram_rdata;
            cbmwg_pkg::OP_WRITE: w_s1_read_data = 8'h00;
            default:             w_s1_read_data = r_s1.data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (w_s1_advance) begin
                r_s1_valid <= o_pop;
                r_s1       <= i_q_entry;
            end
            if (w_out_free) begin
                r_out_valid       <= r_s1_valid;
                r_out_kind        <= r_s1.kind;
                r_out_read_data   <= w_s1_read_data;
                r_out_rom_address <= r_s1.rom_address;
                r_out_mirror      <= r_s1.mirror_vertical;
            end
        end
    end

    assign o_clearing            = r_clearing;
    assign o_out_valid           = r_out_valid;
    assign o_out_kind            = r_out_kind;
    assign o_out_read_data       = r_out_read_data;
    assign o_out_rom_address     = r_out_rom_address;
    assign o_out_mirror_vertical = r_out_mirror;

endmodule

### verif/cartridge_bank_mapper_wram_guard_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the cartridge bank mapper with guarded work RAM
// Drives bus access items through the valid/stall input channel and predicts
// every result item with a behavioural copy of the mapper: bank registers,
// guard keys, control bits, work RAM image and the three configuration
// registers. A short directed part covers power-on state, the register map,
// the guard windows and the special cases. It is followed by random traffic
// under several configurations, with random idling on both channels, and
// ends with a stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_wram_guard_tb;

    // Access kinds on the func field.
    localparam logic [1:0] FUNC_CPU_WRITE = 2'd0;
    localparam logic [1:0] FUNC_CPU_READ  = 2'd1;
    localparam logic [1:0] FUNC_PPU_FETCH = 2'd2;
    localparam logic [1:0] FUNC_UNUSED    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BANK_ORDER = 2'd0;
    localparam logic [1:0] CFG_PRG_MASK   = 2'd1;
    localparam logic [1:0] CFG_CHR_MASK   = 2'd2;

    // CPU and PPU address map.
    localparam logic [15:0] WRAM_BASE   = 16'h6000;
    localparam logic [15:0] GUARD1_BASE = 16'h6800;
    localparam logic [15:0] GUARD2_BASE = 16'h7000;
    localparam logic [15:0] GUARD_END   = 16'h73FF;
    localparam logic [15:0] OPEN_BASE   = 16'h7400;
    localparam logic [15:0] REG_BASE    = 16'h7EF0;
    localparam logic [15:0] REG_END     = 16'h7EFF;
    localparam logic [15:0] PRG_BASE    = 16'h8000;
    localparam logic [15:0] PPU_SPACE   = 16'h2000;

    // Register slots, selected by the low address nibble.
    localparam logic [3:0] SLOT_CTRL = 4'd6;
    localparam logic [3:0] SLOT_KEY0 = 4'd7;
    localparam logic [3:0] SLOT_KEY1 = 4'd8;
    localparam logic [3:0] SLOT_KEY2 = 4'd9;
    localparam logic [3:0] SLOT_PRG0 = 4'd10;
    localparam logic [3:0] SLOT_PRG2 = 4'd12;

    // Values that open each guard window.
    localparam logic [7:0] KEY0_MAGIC = 8'hCA;
    localparam logic [7:0] KEY1_MAGIC = 8'h69;
    localparam logic [7:0] KEY2_MAGIC = 8'h84;

    // The clearing pass after reset keeps the input stalled while it writes every
    // work RAM byte, so the watchdog limit is several times the RAM size.
    localparam int unsigned STALL_LIMIT   = 40000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_ITEMS   = 250;

    typedef struct packed {
        cbmwg_pkg::t_kind kind;
        logic [7:0]       read_data;
        logic [18:0]      rom_address;
        logic             mirror_vertical;
    } t_bus_result;

    // ------------------------------------------------------------------------
    // Clock, stimulus signals and the block itself
    // ------------------------------------------------------------------------
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic [1:0]  in_func      = 2'd0;
    logic [15:0] in_address   = 16'd0;
    logic [7:0]  in_wdata     = 8'd0;
    logic [7:0]  in_open_bus  = 8'd0;
    logic        out_stall    = 1'b0;
    logic        cfg_we       = 1'b0;
    logic [1:0]  cfg_index    = 2'd0;
    logic [7:0]  cfg_data     = 8'd0;

    logic        in_stall;
    logic        out_valid;
    logic [2:0]  out_kind;
    logic [7:0]  out_read_data;
    logic [18:0] out_rom_address;
    logic        out_mirror_vertical;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cartridge_bank_mapper_wram_guard u_dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .o_in_stall            (in_stall),
        .i_in_func             (in_func),
        .i_in_address          (in_address),
        .i_in_write_data       (in_wdata),
        .i_in_open_bus_data    (in_open_bus),
        .o_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .o_out_kind            (out_kind),
        .o_out_read_data       (out_read_data),
        .o_out_rom_address     (out_rom_address),
        .o_out_mirror_vertical (out_mirror_vertical),
        .i_cfg_we              (cfg_we),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predicted mapper state. It is updated in the order in which items are
    // accepted, so each expectation reflects every earlier access.
    // ------------------------------------------------------------------------
    logic [7:0] chr_regs [0:5];
    logic [7:0] prg_regs [0:2];
    logic [7:0] key_regs [0:2];
    logic [1:0] ctrl_reg;
    logic [7:0] wram_image [0:cbmwg_pkg::WRAM_BYTES-1];
    logic       order_reversed;
    logic [5:0] prg_mask;
    logic [7:0] chr_mask;

    t_bus_result pending_results [$];
    int unsigned failures = 0;
    bit          idle_on  = 1'b1;

    // Each of the three guarded windows has its own key; the unguarded upper
    // part of the RAM never counts as open here.
    function automatic logic guard_open(input logic [15:0] addr);
        if (addr >= WRAM_BASE && addr < GUARD1_BASE) return key_regs[0] == KEY0_MAGIC;
        if (addr >= GUARD1_BASE && addr < GUARD2_BASE) return key_regs[1] == KEY1_MAGIC;
        if (addr >= GUARD2_BASE && addr <= GUARD_END) return key_regs[2] == KEY2_MAGIC;
        return 1'b0;
    endfunction

    // A PRG register gives its bank either as its six low bits mirrored or as
    // the register shifted right by two.
    function automatic logic [5:0] prg_window_bank(input logic [7:0] v);
        if (order_reversed) return {v[0], v[1], v[2], v[3], v[4], v[5]};
        return v[7:2];
    endfunction

    function automatic t_bus_result predict_access(input logic [1:0] func,
                                                   input logic [15:0] addr,
                                                   input logic [7:0] wdata,
                                                   input logic [7:0] obus);
        t_bus_result r;
        logic [3:0]  slot;
        logic [1:0]  window;
        logic [5:0]  pbank;
        logic [7:0]  cbank;
        logic [12:0] ppu;
        r.kind        = cbmwg_pkg::KIND_IGNORED;
        r.read_data   = 8'd0;
        r.rom_address = 19'd0;
        slot          = addr[3:0];
        case (func)
            FUNC_CPU_WRITE: begin
                if (addr >= REG_BASE && addr <= REG_END) begin
                    r.kind = cbmwg_pkg::KIND_REG;
                    if (slot < SLOT_CTRL) chr_regs[slot] = wdata;
                    else if (slot == SLOT_CTRL) ctrl_reg = wdata[1:0];
                    else if (slot <= SLOT_KEY2) key_regs[slot - SLOT_KEY0] = wdata;
                    else if (slot <= SLOT_PRG2) prg_regs[slot - SLOT_PRG0] = wdata;
                    else r.kind = cbmwg_pkg::KIND_IGNORED;
                end else if (addr >= WRAM_BASE && addr <= GUARD_END && guard_open(addr)) begin
                    wram_image[addr[12:0]] = wdata;
                    r.kind = cbmwg_pkg::KIND_RAM_WRITE;
                end
            end
            FUNC_CPU_READ: begin
                if (addr >= PRG_BASE) begin
                    window = addr[14:13];
                    // The top window is always the last bank.
                    if (window == 2'd3) pbank = 6'h3F;
                    else pbank = prg_window_bank(prg_regs[window]);
                    pbank         = pbank & prg_mask;
                    r.kind        = cbmwg_pkg::KIND_PRG;
                    r.rom_address = {pbank, addr[12:0]};
                end else if (addr >= OPEN_BASE) begin
                    r.kind      = cbmwg_pkg::KIND_RAM_READ;
                    r.read_data = wram_image[addr[12:0]];
                end else if (addr >= WRAM_BASE) begin
                    if (guard_open(addr)) begin
                        r.kind      = cbmwg_pkg::KIND_RAM_READ;
                        r.read_data = wram_image[addr[12:0]];
                    end else begin
                        r.kind      = cbmwg_pkg::KIND_OPEN_BUS;
                        r.read_data = obus;
                    end
                end
            end
            FUNC_PPU_FETCH: begin
                if (addr < PPU_SPACE) begin
                    // Control bit 1 swaps the two pattern table halves.
                    ppu = addr[12:0] ^ {ctrl_reg[1], 12'd0};
                    if (!ppu[12]) cbank = {chr_regs[ppu[11]][7:1], ppu[10]};
                    else cbank = chr_regs[2 + ppu[11:10]];
                    cbank         = cbank & chr_mask;
                    r.kind        = cbmwg_pkg::KIND_CHR;
                    r.rom_address = {1'b0, cbank, addr[9:0]};
                end
            end
            default: r.kind = cbmwg_pkg::KIND_IGNORED;
        endcase
        r.mirror_vertical = ctrl_reg[0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: stalls in random bursts while idling is on.
    // ------------------------------------------------------------------------
    int unsigned stall_left = 0;

    always @(posedge clk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 13);
        if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result item is matched against the
    // oldest expectation, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_results
        t_bus_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: kind %0d", out_kind);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (out_kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, out_kind);
                    failures++;
                end
                if (out_read_data !== want.read_data) begin
                    $error("read_data: expected 0x%02h, actual 0x%02h",
                           want.read_data, out_read_data);
                    failures++;
                end
                if (out_rom_address !== want.rom_address) begin
                    $error("rom_address: expected 0x%05h, actual 0x%05h",
                           want.rom_address, out_rom_address);
                    failures++;
                end
                if (out_mirror_vertical !== want.mirror_vertical) begin
                    $error("mirror_vertical: expected %0b, actual %0b",
                           want.mirror_vertical, out_mirror_vertical);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if neither channel moves an item for too long.
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("cartridge_bank_mapper_wram_guard_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------------

    // Offers one item and returns at the edge where it is taken. The valid
    // stays high unless a random gap follows, so the next call can present
    // its item straight away.
    task automatic send_access(input logic [1:0] func, input logic [15:0] addr,
                               input logic [7:0] wdata, input logic [7:0] obus);
        in_valid    <= 1'b1;
        in_func     <= func;
        in_address  <= addr;
        in_wdata    <= wdata;
        in_open_bus <= obus;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(predict_access(func, addr, wdata, obus));
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Lowers the valid and waits until every predicted result has arrived,
    // then waits a settling time so that the block is idle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three configuration registers on consecutive edges.
    task automatic load_mapper_cfg(input logic [7:0] order_data, input logic [7:0] pmask,
                                   input logic [7:0] cmask);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BANK_ORDER;
        cfg_data  <= order_data;
        @(posedge clk);
        cfg_index <= CFG_PRG_MASK;
        cfg_data  <= pmask;
        @(posedge clk);
        cfg_index <= CFG_CHR_MASK;
        cfg_data  <= cmask;
        @(posedge clk);
        cfg_we         <= 1'b0;
        order_reversed = order_data[0];
        prg_mask       = pmask[5:0];
        chr_mask       = cmask;
    endtask

    // Work RAM addresses: half clustered around the 1 KB boundaries so that
    // reads often find earlier writes and the window edges are crossed, half
    // spread over the whole RAM.
    function automatic logic [15:0] wram_address();
        if ($urandom_range(0, 1) == 0)
            return 16'(WRAM_BASE + 16'h0400 * $urandom_range(0, 7)
                       + $urandom_range(0, 31) - 16);
        return WRAM_BASE + 16'($urandom_range(0, 16'h1FFF));
    endfunction

    // One random item. Most items are well-formed accesses; key writes carry
    // the magic value more often than not, so the guards open and close
    // throughout. A tenth are fully random noise, unused func value included.
    task automatic send_random_access();
        int unsigned pick;
        logic [3:0]  slot;
        logic [7:0]  wdata;
        pick  = $urandom_range(0, 99);
        wdata = 8'($urandom_range(0, 255));
        if (pick < 15) begin
            slot = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 2) != 0) begin
                case (slot)
                    SLOT_KEY0: wdata = KEY0_MAGIC;
                    SLOT_KEY1: wdata = KEY1_MAGIC;
                    SLOT_KEY2: wdata = KEY2_MAGIC;
                    default:   wdata = wdata;
                endcase
            end
            send_access(FUNC_CPU_WRITE, REG_BASE | {12'd0, slot}, wdata,
                        8'($urandom_range(0, 255)));
        end else if (pick < 35) begin
            send_access(FUNC_CPU_WRITE, wram_address(), wdata, 8'($urandom_range(0, 255)));
        end else if (pick < 55) begin
            send_access(FUNC_CPU_READ, wram_address(), wdata, 8'($urandom_range(0, 255)));
        end else if (pick < 70) begin
            send_access(FUNC_CPU_READ, PRG_BASE | 16'($urandom_range(0, 16'h7FFF)), wdata,
                        8'($urandom_range(0, 255)));
        end else if (pick < 90) begin
            send_access(FUNC_PPU_FETCH, 16'($urandom_range(0, PPU_SPACE - 1)), wdata,
                        8'($urandom_range(0, 255)));
        end else begin
            send_access(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)), wdata,
                        8'($urandom_range(0, 255)));
        end
    endtask

    // A phase of random traffic under one configuration. Idling is chosen
    // afresh every fifty items, so some stretches run with no gaps at all.
    task automatic run_traffic(input logic [7:0] order_data, input logic [7:0] pmask,
                               input logic [7:0] cmask, input bit with_idling);
        wait_drained();
        load_mapper_cfg(order_data, pmask, cmask);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 50 == 0) idle_on = with_idling && ($urandom_range(0, 3) != 0);
            send_random_access();
        end
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // State straight after reset: cleared RAM, closed guards, bank registers
    // at zero and the default masks.
    task automatic test_power_on_state();
        send_access(FUNC_CPU_READ, OPEN_BASE, 8'h00, 8'hFF);
        send_access(FUNC_CPU_READ, WRAM_BASE, 8'h00, 8'hFF);
        send_access(FUNC_CPU_READ, PRG_BASE, 8'h00, 8'h00);
        send_access(FUNC_CPU_READ, 16'hFFFF, 8'hFF, 8'h00);
        send_access(FUNC_PPU_FETCH, PPU_SPACE - 1, 8'h00, 8'h00);
        send_access(FUNC_PPU_FETCH, PPU_SPACE, 8'h00, 8'h00);
        send_access(FUNC_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);
    endtask

    // Register map, guard windows and the cases where an access is dropped.
    task automatic test_guarded_work_ram();
        send_access(FUNC_CPU_WRITE, WRAM_BASE, 8'hA5, 8'h00);       // guard closed
        send_access(FUNC_CPU_READ, WRAM_BASE - 1, 8'h00, 8'h00);    // below the RAM
        send_access(FUNC_CPU_WRITE, REG_BASE + SLOT_KEY0, KEY0_MAGIC, 8'h00);
        send_access(FUNC_CPU_WRITE, REG_BASE + SLOT_KEY1, KEY1_MAGIC, 8'h00);
        send_access(FUNC_CPU_WRITE, REG_BASE + SLOT_KEY2, KEY2_MAGIC, 8'h00);
        send_access(FUNC_CPU_WRITE, WRAM_BASE, 8'hFF, 8'h00);
        send_access(FUNC_CPU_WRITE, GUARD_END, 8'h5A, 8'h00);
        send_access(FUNC_CPU_WRITE, OPEN_BASE, 8'h11, 8'h00);       // unguarded part
        send_access(FUNC_CPU_READ, GUARD_END, 8'h00, 8'h00);
        send_access(FUNC_CPU_WRITE, REG_END - 2, 8'hFF, 8'h00);     // unused slots
        send_access(FUNC_CPU_WRITE, REG_END, 8'hFF, 8'h00);
        send_access(FUNC_CPU_WRITE, REG_BASE + SLOT_CTRL, 8'hFF, 8'h00);
        send_access(FUNC_CPU_WRITE, REG_BASE + SLOT_PRG2, 8'hFF, 8'h00);
        send_access(FUNC_CPU_READ, 16'hC000, 8'h00, 8'h00);
        send_access(FUNC_CPU_WRITE, REG_BASE + 16'd2, 8'hFF, 8'h00);
        send_access(FUNC_PPU_FETCH, 16'h0000, 8'h00, 8'h00);        // halves swapped
        send_access(FUNC_CPU_WRITE, REG_BASE + SLOT_KEY0, 8'h00, 8'h00);
        send_access(FUNC_CPU_READ, WRAM_BASE, 8'h00, 8'h3C);        // closed again
    endtask

    // Both masks at their widest and narrowest, with both bank orders. The
    // widest case also drives the unused upper bits of the mask data.
    task automatic test_mask_extremes();
        run_traffic(8'h00, 8'hFF, 8'hFF, 1'b1);
        run_traffic(8'h01, 8'h00, 8'h00, 1'b1);
    endtask

    task automatic test_reversed_order();
        run_traffic(8'hFF, 8'h3F, 8'hFF, 1'b1);
    endtask

    task automatic test_partial_masks();
        run_traffic(8'h00, 8'h07, 8'h1F, 1'b1);
    endtask

    task automatic test_random_settings();
        run_traffic(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'b1);
        run_traffic(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Last part of the run: one item per cycle with no idling on either side.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        run_traffic(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < 6; i++) chr_regs[i] = 8'd0;
        for (int i = 0; i < 3; i++) begin
            prg_regs[i] = 8'd0;
            key_regs[i] = 8'd0;
        end
        for (int i = 0; i < cbmwg_pkg::WRAM_BYTES; i++) wram_image[i] = 8'd0;
        ctrl_reg       = 2'd0;
        order_reversed = 1'b0;
        prg_mask       = 6'd15;
        chr_mask       = 8'd127;

        // Reset is held first; the clearing pass that follows shows
        // up only as a long input stall.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_power_on_state();
        test_guarded_work_ram();
        test_mask_extremes();
        test_reversed_order();
        test_partial_masks();
        test_random_settings();
        test_back_to_back();
        wait_drained();

        if (failures == 0) $display("cartridge_bank_mapper_wram_guard_tb: PASS");
        else $display("cartridge_bank_mapper_wram_guard_tb: FAIL");
        $finish;
    end

endmodule
